>>> src/brs_pkg.sv
// Shared types, constants and helpers for the bit-vector rank/select engine.
// Used by brs_ctrl, brs_dp and bitvector_rank_select_top; depends on nothing.
package brs_pkg;

    localparam int VAL_W          = 13;
    localparam int OP_W           = 3;
    localparam int MAX_BITS_DEF   = 4096;
    localparam int BLOCK_BITS_DEF = 64;
    localparam int BLK_MAX        = 64;
    localparam int PC_W           = 7;
    localparam int VAL_MAX        = (1 << VAL_W) - 1;

    localparam logic [VAL_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_SET     = 3'd0,
        OP_FINISH  = 3'd1,
        OP_RANK1   = 3'd2,
        OP_RANK0   = 3'd3,
        OP_SELECT1 = 3'd4,
        OP_SELECT0 = 3'd5,
        OP_ACCESS  = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRB_RD,
        S_PRB_PC,
        S_SEL_TEST,
        S_SEL_EVAL,
        S_FIN_RD,
        S_FIN_ACC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic rd_fin;
        logic pc;
        logic mid;
        logic eval;
        logic acc;
        logic emit;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic sel_bad;
        logic lo_ge_hi;
        logic fin_last;
    } t_dp_stat;

    // SWAR popcount over one 64-bit word, summed bytewise without a multiply
    function automatic logic [PC_W-1:0] popcount64(input logic [BLK_MAX-1:0] x);
        logic [BLK_MAX-1:0] a;
        logic [BLK_MAX-1:0] b;
        logic [BLK_MAX-1:0] c;
        logic [BLK_MAX-1:0] d;
        logic [BLK_MAX-1:0] e;
        logic [BLK_MAX-1:0] f;
        a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        d = c + (c >> 8);
        e = d + (d >> 16);
        f = e + (e >> 32);
        return f[PC_W-1:0];
    endfunction

endpackage

>>> src/brs_ctrl.sv
// Sequencer for the rank/select engine: one state machine shared by all operations.
// Depends on brs_pkg; drives brs_dp through t_dp_cmd and reads t_dp_stat.
module brs_ctrl
    import brs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  t_dp_stat        i_stat,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    cur_op;

    assign cur_op = (r_state == S_IDLE) ? t_op'(i_op) : r_op;
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op <= t_op'(i_op);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (cur_op)
                        OP_SET, OP_RANK1, OP_RANK0, OP_ACCESS: n_state = S_PRB_RD;
                        OP_FINISH:                             n_state = S_FIN_RD;
                        OP_SELECT1, OP_SELECT0:                n_state = S_SEL_TEST;
                        default:                               n_state = S_EMIT;
                    endcase
                end
            end
            S_PRB_RD: begin
                n_state = (r_op inside {OP_SET, OP_ACCESS}) ? S_EMIT : S_PRB_PC;
            end
            S_PRB_PC: begin
                n_state = (r_op inside {OP_RANK1, OP_RANK0}) ? S_EMIT : S_SEL_EVAL;
            end
            S_SEL_TEST: begin
                n_state = (i_stat.sel_bad || i_stat.lo_ge_hi) ? S_EMIT : S_PRB_RD;
            end
            S_SEL_EVAL: n_state = S_SEL_TEST;
            S_FIN_RD:   n_state = S_FIN_ACC;
            S_FIN_ACC:  n_state = i_stat.fin_last ? S_EMIT : S_FIN_RD;
            S_EMIT:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_cmd.op = cur_op;
        case (r_state)
            S_IDLE:     o_cmd.load = i_start;
            S_PRB_RD:   o_cmd.rd = 1'b1;
            S_PRB_PC:   o_cmd.pc = 1'b1;
            S_SEL_TEST: o_cmd.mid = !(i_stat.sel_bad || i_stat.lo_ge_hi);
            S_SEL_EVAL: o_cmd.eval = 1'b1;
            S_FIN_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_fin = 1'b1;
            end
            S_FIN_ACC:  o_cmd.acc = 1'b1;
            S_EMIT:     o_cmd.emit = 1'b1;
            default:    ;
        endcase
    end

endmodule

>>> src/brs_dp.sv
// Datapath of the rank/select engine: block and prefix memories, rank probe,
// search window, prefix rebuild and result register. Depends on brs_pkg.
module brs_dp
    import brs_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [VAL_W-1:0] i_index,
    input  logic [VAL_W-1:0] i_len,
    output t_dp_stat         o_stat,
    output logic             o_result_valid,
    output logic [VAL_W-1:0] o_value,
    output logic             o_error
);

    localparam int NB    = (MAX_BITS + BLOCK_BITS - 1) / BLOCK_BITS;
    localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
    localparam int LW    = $clog2(BLOCK_BITS);
    localparam int RK    = VAL_W + $clog2(BLK_MAX);
    localparam int RECIP = ((1 << RK) + BLOCK_BITS - 1) / BLOCK_BITS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int QW    = VAL_W + RW - RK;
    localparam int PW    = VAL_W + RW;

    localparam logic [BW-1:0]    LastBlk = BW'(NB - 1);
    localparam logic [RW-1:0]    RecipC  = RW'(RECIP);
    localparam logic [VAL_W-1:0] BlkBits = VAL_W'(BLOCK_BITS);

    // storage
    logic [BLOCK_BITS-1:0] blk_mem [NB];
    logic [VAL_W-1:0]      pfx_mem [NB];
    logic [NB-1:0]         r_blk_vld;
    logic                  r_pfx_vld;

    // counters and scalar state
    logic [VAL_W-1:0] r_ones;
    logic [VAL_W-1:0] r_highest;
    logic             r_hvld;
    logic [VAL_W-1:0] r_stored;

    // probe and search registers
    logic [VAL_W-1:0]      r_pos;
    logic [VAL_W-1:0]      r_tgt;
    logic [VAL_W-1:0]      r_lo;
    logic [VAL_W-1:0]      r_hi;
    logic [BW-1:0]         r_q;
    logic                  r_ge_len;
    logic                  r_ge_stored;
    logic [BLOCK_BITS-1:0] r_blk_raw;
    logic                  r_blk_ok;
    logic [VAL_W-1:0]      r_pfx_raw;
    logic                  r_pfx_ok;
    logic [PC_W-1:0]       r_above;
    logic [BW-1:0]         r_k;
    logic [VAL_W-1:0]      r_acc;

    // result register
    logic             r_res_vld;
    logic [VAL_W-1:0] r_value;
    logic             r_error;

    logic [PW-1:0]         q_prod;
    logic [QW-1:0]         q_full;
    logic [BW-1:0]         rd_addr;
    logic [VAL_W-1:0]      blk_off;
    logic [LW-1:0]         low;
    logic [BLOCK_BITS-1:0] blk;
    logic [VAL_W-1:0]      pfx;
    logic [BLOCK_BITS-1:0] above_mask;
    logic [PC_W-1:0]       pc_above;
    logic [PC_W-1:0]       pc_full;
    logic [VAL_W-1:0]      acc_n;
    logic [VAL_W-1:0]      rank1;
    logic [VAL_W-1:0]      rank0;
    logic [VAL_W-1:0]      rank_sel;
    logic [VAL_W-1:0]      zeros;
    logic [VAL_W:0]        pos_p1;
    logic [VAL_W:0]        lohi_sum;
    logic                  sel_bad;
    logic                  blk_we;
    logic [BLOCK_BITS-1:0] blk_wdata;
    logic [VAL_W-1:0]      res_val;
    logic                  res_err;

    // block index by reciprocal multiply, exact for every 13-bit position
    assign q_prod  = PW'(r_pos) * PW'(RecipC);
    assign q_full  = q_prod[PW-1:RK];
    assign rd_addr = i_cmd.rd_fin ? r_k : BW'(q_full);

    assign blk_off = VAL_W'(VAL_W'(r_q) * BlkBits);
    assign low     = LW'(r_pos - blk_off);

    assign blk = r_blk_ok ? r_blk_raw : '0;
    assign pfx = r_pfx_ok ? r_pfx_raw : '0;

    assign above_mask = ({BLOCK_BITS{1'b1}} << low) << 1;
    assign pc_above   = popcount64(BLK_MAX'(blk & above_mask));
    assign pc_full    = popcount64(BLK_MAX'(blk));
    assign acc_n      = r_acc + VAL_W'(pc_full);

    assign zeros  = (i_len >= r_ones) ? (i_len - r_ones) : '0;
    assign pos_p1 = {1'b0, r_pos} + 1'b1;
    assign rank1  = r_ge_stored ? r_ones
                  : ((pfx >= VAL_W'(r_above)) ? (pfx - VAL_W'(r_above)) : '0);
    assign rank0  = r_ge_len ? zeros
                  : ((pos_p1 >= {1'b0, rank1}) ? VAL_W'(pos_p1 - {1'b0, rank1}) : '0);
    assign rank_sel = (i_cmd.op inside {OP_RANK0, OP_SELECT0}) ? rank0 : rank1;

    assign lohi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign sel_bad  = (r_tgt == '0)
                   || (r_tgt > ((i_cmd.op == OP_SELECT1) ? r_ones : zeros));

    assign o_stat.sel_bad  = sel_bad;
    assign o_stat.lo_ge_hi = (r_lo >= r_hi);
    assign o_stat.fin_last = (r_k == LastBlk);

    assign blk_we    = i_cmd.emit && (i_cmd.op == OP_SET) && !r_ge_len;
    assign blk_wdata = blk | (BLOCK_BITS'(1) << low);

    // memories: registered read, one write port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_blk_raw <= blk_mem[rd_addr];
            r_pfx_raw <= pfx_mem[rd_addr];
        end
        if (blk_we) begin
            blk_mem[r_q] <= blk_wdata;
        end
        if (i_cmd.acc) begin
            pfx_mem[r_k] <= acc_n;
        end
    end

    // probe, search and rebuild registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= i_index;
            r_tgt <= i_index;
            r_lo  <= '0;
            r_hi  <= i_len;
            r_k   <= '0;
            r_acc <= '0;
        end
        if (i_cmd.rd) begin
            r_q         <= rd_addr;
            r_blk_ok    <= r_blk_vld[rd_addr];
            r_pfx_ok    <= r_pfx_vld;
            r_ge_len    <= (r_pos >= i_len);
            r_ge_stored <= (r_pos >= r_stored);
        end
        if (i_cmd.pc) begin
            r_above <= pc_above;
        end
        if (i_cmd.mid) begin
            r_pos <= lohi_sum[VAL_W:1];
        end
        if (i_cmd.eval) begin
            if (rank_sel < r_tgt) begin
                r_lo <= VAL_W'(pos_p1);
            end else begin
                r_hi <= r_pos;
            end
        end
        if (i_cmd.acc) begin
            r_acc <= acc_n;
            r_k   <= r_k + 1'b1;
        end
        if (blk_we && (!r_hvld || r_pos > r_highest)) begin
            r_highest <= r_pos;
        end
        if (i_cmd.emit) begin
            r_value <= res_val;
            r_error <= res_err;
        end
    end

    // result by operation
    always_comb begin
        res_val = '0;
        res_err = 1'b0;
        case (i_cmd.op)
            OP_SET:   res_err = r_ge_len;
            OP_RANK1: res_val = rank1;
            OP_RANK0: res_val = rank0;
            OP_SELECT1, OP_SELECT0: begin
                res_err = sel_bad;
                res_val = sel_bad ? '0 : r_lo;
            end
            OP_ACCESS: begin
                res_err = r_ge_len;
                res_val = (r_ge_len || r_ge_stored) ? '0 : VAL_W'(blk[low]);
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= '0;
            r_pfx_vld <= 1'b0;
            r_ones    <= '0;
            r_hvld    <= 1'b0;
            r_stored  <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.emit;
            if (i_cmd.emit) begin
                case (i_cmd.op)
                    OP_SET: begin
                        if (!r_ge_len) begin
                            r_blk_vld[r_q] <= 1'b1;
                            r_hvld         <= 1'b1;
                            if (!blk[low]) begin
                                r_ones <= r_ones + 1'b1;
                            end
                        end
                    end
                    OP_FINISH: begin
                        r_stored  <= r_hvld ? VAL_W'(r_highest + 1'b1) : '0;
                        r_pfx_vld <= 1'b1;
                    end
                    OP_CLEAR: begin
                        r_blk_vld <= '0;
                        r_pfx_vld <= 1'b0;
                        r_ones    <= '0;
                        r_hvld    <= 1'b0;
                        r_stored  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_value        = r_value;
    assign o_error        = r_error;

    a_probe_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (r_pos >= r_lo) && (r_pos < r_hi))
        else $error("search probe outside the lo/hi window");

    a_ones_need_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hvld |-> (r_ones == '0))
        else $error("ones count nonzero with no bit set");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |=> !r_res_vld)
        else $error("result strobe held for two cycles");

endmodule

>>> src/bitvector_rank_select_top.sv
// Top level of the bit-vector rank/select engine: configuration register,
// length clamp, sequencer and datapath. Depends on brs_pkg, brs_ctrl, brs_dp.
//
//  channel   | direction | handshake                    | word
//  ----------+-----------+------------------------------+----------------------------
//  command   | in        | start high while busy low    | i_op, i_index
//  result    | out       | o_result_valid, one cycle    | o_value, o_error
//  config    | in        | i_cfg_valid and o_cfg_ready  | i_cfg_vector_length
//
// Busy states per command word: set and access read the block and emit,
// rank adds a popcount, clear only emits, finish reads each block and
// writes its prefix before emitting, and select tests the window and runs
// up to 13 rank probes, one probe being block/prefix read, popcount, compare.
// The result strobe rises in the cycle after the last busy cycle; a new
// command word is taken in that same cycle. The result side cannot stall.
// Reset clears the store at once through per-block valid bits and a prefix
// valid flag, so there is no clearing pass; vector_length resets to 4096.
module bitvector_rank_select_top
    import brs_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_index,
    output logic             o_result_valid,
    output logic [VAL_W-1:0] o_value,
    output logic             o_error,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VAL_W-1:0] i_cfg_vector_length
);

    // largest length the store can hold, as seen through a 13-bit field
    localparam int               LEN_CAP = (MAX_BITS > VAL_MAX) ? VAL_MAX : MAX_BITS;
    localparam logic [VAL_W-1:0] LenCap  = VAL_W'(LEN_CAP);

    logic [VAL_W-1:0] r_vector_length;
    logic [VAL_W-1:0] eff_len;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    // take configuration words only between commands
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vector_length <= i_cfg_vector_length;
        end
    end

    // saturate the programmed length at the store size
    assign eff_len = (r_vector_length > LenCap) ? LenCap : r_vector_length;

    brs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    brs_dp #(
        .MAX_BITS   (MAX_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_index        (i_index),
        .i_len          (eff_len),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_value        (o_value),
        .o_error        (o_error)
    );

endmodule

>>> tb/brs_checker.sv
// Checker for the bit-vector rank/select engine: watches the command, result
// and length-register channels, predicts every result word and compares it.
// Depends on brs_pkg for the operation codes and field widths.
module brs_checker
    import brs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_index,
    input  logic             o_result_valid,
    input  logic [VAL_W-1:0] o_value,
    input  logic             o_error,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [VAL_W-1:0] i_cfg_vector_length,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = BLOCK_BITS_DEF;
    localparam int WORDS     = MAX_BITS_DEF / BLOCK_BITS_DEF;

    typedef struct {
        t_op              op;
        logic [VAL_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic             error;
    } t_result;

    t_result results_due[$];

    logic [WORD_BITS-1:0] bit_words [WORDS];
    int unsigned          run_ones  [WORDS];
    int unsigned          ones_cnt;
    int unsigned          top_one;
    bit                   top_valid;
    int unsigned          stored_len;
    int unsigned          len_reg;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input t_result want,
                                   input int got_v, input int want_v);
        if (fail_count < 40)
            $display("[%0t] %s mismatch, %s index %0d: got %0d, want %0d",
                     $time, what, want.op.name(), want.index, got_v, want_v);
        fail_count++;
    endtask

    task automatic wipe_store();
        for (int w = 0; w < WORDS; w++) begin
            bit_words[w] = '0;
            run_ones[w]  = 0;
        end
        ones_cnt   = 0;
        top_one    = 0;
        top_valid  = 1'b0;
        stored_len = 0;
    endtask

    function automatic int unsigned eff_len();
        return (len_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : len_reg;
    endfunction

    // Inclusive count of ones; past the finished length the grand total holds.
    function automatic int unsigned ones_upto(input int unsigned pos);
        int unsigned w;
        int unsigned above;
        if (pos >= stored_len)
            return ones_cnt;
        w     = pos / WORD_BITS;
        above = $countones(bit_words[w] & (64'hFFFF_FFFF_FFFF_FFFE << (pos % WORD_BITS)));
        return (run_ones[w] >= above) ? run_ones[w] - above : 0;
    endfunction

    function automatic int unsigned zeros_upto(input int unsigned pos);
        int unsigned n;
        int unsigned r;
        n = eff_len();
        if (pos >= n)
            return (n >= ones_cnt) ? n - ones_cnt : 0;
        r = ones_upto(pos);
        return (pos + 1 >= r) ? pos + 1 - r : 0;
    endfunction

    function automatic int unsigned find_nth(input int unsigned target, input bit zeros);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned r;
        lo = 0;
        hi = eff_len();
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            r   = zeros ? zeros_upto(mid) : ones_upto(mid);
            if (r < target)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic predict(input t_op op, input logic [VAL_W-1:0] idx_in,
                           output t_result res);
        int unsigned n;
        int unsigned idx;
        int unsigned w;
        int unsigned acc;
        int unsigned zeros;
        n         = eff_len();
        idx       = idx_in;
        res.op    = op;
        res.index = idx_in;
        res.value = '0;
        res.error = 1'b0;
        case (op)
            OP_SET: begin
                if (idx >= n) begin
                    res.error = 1'b1;
                end else begin
                    w = idx / WORD_BITS;
                    if (!bit_words[w][idx % WORD_BITS]) begin
                        bit_words[w][idx % WORD_BITS] = 1'b1;
                        ones_cnt++;
                    end
                    if (!top_valid || idx > top_one) begin
                        top_one   = idx;
                        top_valid = 1'b1;
                    end
                end
            end
            OP_FINISH: begin
                stored_len = top_valid ? top_one + 1 : 0;
                acc = 0;
                for (int b = 0; b < WORDS; b++) begin
                    acc += $countones(bit_words[b]);
                    run_ones[b] = acc;
                end
            end
            OP_RANK1: res.value = VAL_W'(ones_upto(idx));
            OP_RANK0: res.value = VAL_W'(zeros_upto(idx));
            OP_SELECT1: begin
                if (idx < 1 || idx > ones_cnt)
                    res.error = 1'b1;
                else
                    res.value = VAL_W'(find_nth(idx, 1'b0));
            end
            OP_SELECT0: begin
                zeros = (n >= ones_cnt) ? n - ones_cnt : 0;
                if (idx < 1 || idx > zeros)
                    res.error = 1'b1;
                else
                    res.value = VAL_W'(find_nth(idx, 1'b1));
            end
            OP_ACCESS: begin
                if (idx >= n)
                    res.error = 1'b1;
                else if (idx < stored_len)
                    res.value = VAL_W'(bit_words[idx / WORD_BITS][idx % WORD_BITS]);
            end
            default: wipe_store();
        endcase
    endtask

    // Compare before accepting: a word taken at this edge cannot already have
    // its result on the ports.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            wipe_store();
            len_reg = LEN_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                len_reg = i_cfg_vector_length;
            if (o_result_valid) begin
                if (results_due.size() == 0) begin
                    want.op    = OP_CLEAR;
                    want.index = '0;
                    report_mismatch("unexpected result", want, o_value, -1);
                end else begin
                    want = results_due.pop_front();
                    if (o_value !== want.value)
                        report_mismatch("value", want, o_value, want.value);
                    if (o_error !== want.error)
                        report_mismatch("error", want, o_error, want.error);
                end
            end
            if (start && !busy) begin
                predict(t_op'(i_op), i_index, want);
                results_due.push_back(want);
            end
        end
        pending = results_due.size();
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for bitvector_rank_select_top: clock, reset, command and
// length-register stimulus, verdict. Depends on brs_pkg and brs_checker.
module tb_top;
    import brs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 2000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  i_op;
    logic [VAL_W-1:0] i_index;
    logic             o_result_valid;
    logic [VAL_W-1:0] o_value;
    logic             o_error;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [VAL_W-1:0] i_cfg_vector_length;

    int fail_count;
    int pending;

    // Stimulus bookkeeping only; the checker owns the real prediction.
    bit          idle_on;
    int          words_sent;
    int unsigned len_now;
    int unsigned ones_guess;

    bitvector_rank_select_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_op                (i_op),
        .i_index             (i_index),
        .o_result_valid      (o_result_valid),
        .o_value             (o_value),
        .o_error             (o_error),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_vector_length (i_cfg_vector_length)
    );

    brs_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_op                (i_op),
        .i_index             (i_index),
        .o_result_valid      (o_result_valid),
        .o_value             (o_value),
        .o_error             (o_error),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_vector_length (i_cfg_vector_length),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (every word a finish, with gaps) stays
    // under a tenth of this.
    initial begin
        #30_000_000;
        $display("** bitvector_rank_select_top: FAILED **");
        $finish;
    end

    // Present one command word and hold it until the engine takes it. Each
    // cycle may randomly drop start for a bubble, so gaps land both while the
    // engine is busy and right at the cycle it frees up.
    task automatic send_cmd(input t_op op, input logic [VAL_W-1:0] idx);
        bit hold;
        forever begin
            hold = idle_on && ($urandom_range(0, 99) < 14);
            start   <= !hold;
            i_op    <= op;
            i_index <= idx;
            @(posedge i_clk);
            if (!hold && !busy)
                break;
        end
        words_sent++;
        if (op == OP_SET && idx < eff_now())
            ones_guess++;
        if (op == OP_CLEAR)
            ones_guess = 0;
    endtask

    // Drop start and wait until every result is back, then a few spare cycles.
    // Step to a falling edge first so the checker has seen the last word.
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [VAL_W-1:0] len);
        i_cfg_valid         <= 1'b1;
        i_cfg_vector_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        len_now = len;
    endtask

    function automatic int unsigned eff_now();
        return (len_now > MAX_BITS_DEF) ? MAX_BITS_DEF : len_now;
    endfunction

    // Register settings: the extremes, just around the store size, and
    // often short vectors so the store fills densely.
    function automatic logic [VAL_W-1:0] pick_length();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return VAL_W'(1);
            2:       return VAL_W'(64);
            3:       return VAL_W'(65);
            4:       return VAL_W'(4095);
            5:       return VAL_W'(4096);
            6:       return VAL_W'(4097);
            7:       return VAL_W'(8191);
            8:       return VAL_W'($urandom_range(0, 8191));
            default: return VAL_W'($urandom_range(1, 300));
        endcase
    endfunction

    // Bit position: mostly inside the vector, plus its edges and the full field.
    function automatic logic [VAL_W-1:0] pick_pos();
        int unsigned n;
        n = eff_now();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_W'((n > 0) ? n - 1 : 0);
            2:       return VAL_W'(n);
            3:       return VAL_W'($urandom_range(0, 8191));
            default: return VAL_W'((n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 8191));
        endcase
    endfunction

    // Select ordinal around the rough count of ones (or zeros) in the store.
    function automatic logic [VAL_W-1:0] pick_ordinal(input bit zeros);
        int unsigned n;
        int unsigned tgt;
        n   = eff_now();
        tgt = zeros ? ((n > ones_guess) ? n - ones_guess : 0) : ones_guess;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return VAL_W'($urandom_range(0, 8191));
            2:       return VAL_W'(tgt + 1);
            3:       return VAL_W'(tgt);
            default: return VAL_W'((tgt == 0) ? 1 : $urandom_range(1, tgt));
        endcase
    endfunction

    // One query word; a few stale sets, finishes and clears mixed in.
    task automatic send_query();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            send_cmd(OP_RANK1, pick_pos());
        else if (pick < 36)
            send_cmd(OP_RANK0, pick_pos());
        else if (pick < 55)
            send_cmd(OP_SELECT1, pick_ordinal(1'b0));
        else if (pick < 74)
            send_cmd(OP_SELECT0, pick_ordinal(1'b1));
        else if (pick < 91)
            send_cmd(OP_ACCESS, pick_pos());
        else if (pick < 96)
            send_cmd(OP_SET, pick_pos());
        else if (pick < 99)
            send_cmd(OP_FINISH, VAL_W'($urandom_range(0, 8191)));
        else
            send_cmd(OP_CLEAR, VAL_W'($urandom_range(0, 8191)));
    endtask

    initial begin
        int unsigned n_set;
        int unsigned n_query;
        int unsigned base;
        bit          clustered;

        i_rst_n             <= 1'b0;
        start               <= 1'b0;
        i_op                <= OP_SET;
        i_index             <= '0;
        i_cfg_valid         <= 1'b0;
        i_cfg_vector_length <= '0;
        idle_on    = 1'b1;
        words_sent = 0;
        len_now    = 4096;
        ones_guess = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at the reset length of 4096.
        send_cmd(OP_RANK1, '0);              // empty store
        send_cmd(OP_RANK0, VAL_W'(8191));    // past the length: length minus ones
        send_cmd(OP_SELECT1, VAL_W'(1));     // no ones yet
        send_cmd(OP_SELECT0, '0);            // ordinal zero
        send_cmd(OP_SELECT0, VAL_W'(4096));  // last zero
        send_cmd(OP_SELECT0, VAL_W'(4097));  // one past the zeros
        send_cmd(OP_ACCESS, '0);
        send_cmd(OP_FINISH, '0);             // finish with no ones
        send_cmd(OP_SET, VAL_W'(4096));      // out of range
        send_cmd(OP_SET, VAL_W'(8191));      // out of range, all index bits high
        send_cmd(OP_SET, VAL_W'(200));
        send_cmd(OP_SET, VAL_W'(200));       // already one: total holds
        send_cmd(OP_FINISH, VAL_W'(8191));
        send_cmd(OP_SET, VAL_W'(10));        // sets after finish leave counts stale
        send_cmd(OP_SET, VAL_W'(20));
        send_cmd(OP_RANK1, VAL_W'(5));       // stale count goes negative, floor at zero
        send_cmd(OP_RANK1, VAL_W'(8191));
        send_cmd(OP_RANK0, VAL_W'(100));
        send_cmd(OP_SELECT1, VAL_W'(1));
        send_cmd(OP_SELECT1, VAL_W'(3));
        send_cmd(OP_SELECT1, VAL_W'(4));     // above the ones count
        send_cmd(OP_ACCESS, VAL_W'(200));
        send_cmd(OP_ACCESS, VAL_W'(4095));   // beyond the finished length
        send_cmd(OP_ACCESS, VAL_W'(4096));   // out of range
        send_cmd(OP_CLEAR, '0);
        send_cmd(OP_RANK1, VAL_W'(4095));
        settle();

        // Random phases: optionally a new length and a clear, a batch of sets,
        // usually a finish, then a run of queries against that store.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 80)
                write_length(pick_length());
            if ($urandom_range(0, 99) < 70)
                send_cmd(OP_CLEAR, VAL_W'($urandom_range(0, 8191)));

            clustered = $urandom_range(0, 1);
            base      = (eff_now() > 128) ? $urandom_range(0, eff_now() - 128) : 0;
            n_set     = $urandom_range(0, 40);
            for (int k = 0; k < n_set; k++) begin
                // Long stretch with start never dropped, away from the edges.
                idle_on = !(words_sent >= 900 && words_sent < 1300);
                if ($urandom_range(0, 99) < 10)
                    send_cmd(OP_SET, VAL_W'($urandom_range(0, 8191)));
                else if (clustered && eff_now() > 0)
                    send_cmd(OP_SET, VAL_W'(base + $urandom_range(0, 127) % eff_now()));
                else
                    send_cmd(OP_SET, pick_pos());
            end
            if ($urandom_range(0, 99) < 85)
                send_cmd(OP_FINISH, VAL_W'($urandom_range(0, 8191)));

            n_query = $urandom_range(10, 40);
            for (int k = 0; k < n_query; k++) begin
                idle_on = !(words_sent >= 900 && words_sent < 1300);
                send_query();
            end
            settle();
        end

        // Everything is back; wait on for any stray results.
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** bitvector_rank_select_top: PASSED **");
        end else begin
            $display("** bitvector_rank_select_top: FAILED **");
        end
        $finish;
    end

endmodule
